// ----- design/tivg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_pkg
// Shared constants, register codes and width helpers for the torus
// implicit value and gradient core.
// ----------------------------------------------------------------------------
package tivg_pkg;

  localparam int AXIS_W      = 16;
  localparam int AXIS_FRAC   = 14;
  localparam int RAD_W       = 16;
  localparam int VALUE_W     = 40;
  localparam int GRAD_W      = 20;
  localparam int LANES       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = ((VALUE_W + 3 * GRAD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_AXIS   = 3'd1,
    REG_MAJOR  = 3'd2,
    REG_MINOR  = 3'd3,
    REG_FLIP   = 3'd4
  } cfg_reg_t;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // point minus center
  function automatic int vec_w(int cw);
    return cw + 1;
  endfunction

  // sum of three vec * axis products
  function automatic int dot_w(int cw);
    return vec_w(cw) + AXIS_W + 2;
  endfunction

  function automatic int para_shift(int f);
    return 2 * AXIS_FRAC - f;
  endfunction

  function automatic int para_w(int cw, int f);
    return dot_w(cw) + AXIS_W - para_shift(f) + 1;
  endfunction

  function automatic int perp_w(int cw, int f);
    return max2(vec_w(cw) + f, para_w(cw, f)) + 1;
  endfunction

  // R * |perp|
  function automatic int mag_w(int cw, int f);
    return RAD_W + perp_w(cw, f);
  endfunction

  // |R * perp / norm| stays below 2^(RAD_W + f + 1)
  function automatic int quo_w(int f);
    return RAD_W + f + 2;
  endfunction

  function automatic int dif_w(int cw, int f);
    return max2(vec_w(cw) + f, quo_w(f) + 1) + 1;
  endfunction

  function automatic int psq_w(int cw, int f);
    return 2 * para_w(cw, f) + 2;
  endfunction

endpackage

// ----- design/tivg_proj.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_proj
// Projection pipeline: offset from center, dot with axis, parallel and
// perpendicular parts, their squared lengths and R * |perp| (seven stages).
// ----------------------------------------------------------------------------
module tivg_proj import tivg_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  localparam int VW   = vec_w(COORD_WIDTH),
  localparam int PW   = perp_w(COORD_WIDTH, FRAC_BITS),
  localparam int MW   = mag_w(COORD_WIDTH, FRAC_BITS),
  localparam int SQW  = 2 * PW,
  localparam int PSQW = psq_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [3*COORD_WIDTH-1:0]     point,
  input  logic [3*COORD_WIDTH-1:0]     center,
  input  logic [3*AXIS_W-1:0]          axis,
  input  logic [RAD_W-1:0]             ring_radius,
  output logic                         out_valid,
  output logic [LANES-1:0][VW-1:0]     vec,
  output logic [LANES-1:0]             perp_neg,
  output logic [LANES-1:0][MW-1:0]     mag,
  output logic [SQW-1:0]               perp_sq,
  output logic [PSQW-1:0]              para_sq
);

  localparam int PRW  = VW + AXIS_W;
  localparam int DOTW = dot_w(COORD_WIDTH);
  localparam int DPW  = DOTW + AXIS_W;
  localparam int PSH  = para_shift(FRAC_BITS);
  localparam logic signed [DPW:0] P_HALF = (DPW+1)'(1) << (PSH - 1);

  logic signed [AXIS_W-1:0] ax [LANES];

  logic                          va, vb, vc, vd, ve, vf, vg;
  logic [LANES-1:0][VW-1:0]      vec_a, vec_b, vec_c, vec_d, vec_e, vec_f;
  logic [LANES-1:0][PRW-1:0]     prod_b;
  logic [DOTW-1:0]               dot_c;
  logic [LANES-1:0][DPW-1:0]     dp_d;
  logic [LANES-1:0][PW-1:0]      para_e, perp_e;
  logic signed [DPW:0]           dp_rnd [LANES];
  logic signed [PW-1:0]          para_n [LANES];
  logic signed [PW-1:0]          perp_n [LANES];
  logic [PW-1:0]                 perp_abs [LANES];
  logic [LANES-1:0][SQW-1:0]     psq_f;
  logic [LANES-1:0][PSQW-1:0]    asq_f;
  logic [LANES-1:0][MW-1:0]      mag_f;
  logic [LANES-1:0]              neg_f;
  logic [LANES-1:0][VW-1:0]      vec_g;
  logic [LANES-1:0][MW-1:0]      mag_g;
  logic [LANES-1:0]              neg_g;
  logic [SQW-1:0]                sq_g;
  logic [PSQW-1:0]               asum_g;

  // unpack the axis components
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ax[i] = $signed(axis[i*AXIS_W +: AXIS_W]);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
      ve <= 1'b0; vf <= 1'b0; vg <= 1'b0;
    end else if (en) begin
      va <= in_valid; vb <= va; vc <= vb; vd <= vc;
      ve <= vd; vf <= ve; vg <= vf;
    end
  end

  // round the scaled parallel part half up, form the perpendicular part
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dp_rnd[i]   = (DPW+1)'($signed(dp_d[i])) + P_HALF;
      para_n[i]   = PW'(dp_rnd[i] >>> PSH);
      perp_n[i]   = (PW'($signed(vec_d[i])) <<< FRAC_BITS) - para_n[i];
      perp_abs[i] = perp_e[i][PW-1] ? PW'(-$signed(perp_e[i])) : perp_e[i];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        vec_a[i] <= VW'($signed(point[i*COORD_WIDTH +: COORD_WIDTH]))
                  - VW'($signed(center[i*COORD_WIDTH +: COORD_WIDTH]));
        prod_b[i] <= PRW'($signed(vec_a[i])) * PRW'(ax[i]);
        dp_d[i]   <= DPW'($signed(dot_c)) * DPW'(ax[i]);
        para_e[i] <= para_n[i];
        perp_e[i] <= perp_n[i];
        psq_f[i]  <= SQW'($signed(perp_e[i])) * SQW'($signed(perp_e[i]));
        asq_f[i]  <= PSQW'($signed(para_e[i])) * PSQW'($signed(para_e[i]));
        mag_f[i]  <= MW'(ring_radius) * MW'(perp_abs[i]);
        neg_f[i]  <= perp_e[i][PW-1];
      end
      vec_b <= vec_a;
      vec_c <= vec_b;
      vec_d <= vec_c;
      vec_e <= vec_d;
      vec_f <= vec_e;
      vec_g <= vec_f;
      dot_c <= DOTW'($signed(prod_b[0])) + DOTW'($signed(prod_b[1]))
             + DOTW'($signed(prod_b[2]));
      sq_g   <= psq_f[0] + psq_f[1] + psq_f[2];
      asum_g <= asq_f[0] + asq_f[1] + asq_f[2];
      mag_g  <= mag_f;
      neg_g  <= neg_f;
    end
  end

  assign out_valid = vg;
  assign vec       = vec_g;
  assign perp_neg  = neg_g;
  assign mag       = mag_g;
  assign perp_sq   = sq_g;
  assign para_sq   = asum_g;

endmodule

// ----- design/tivg_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_sqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module tivg_sqrt import tivg_pkg::*; #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 8,
  localparam int RW    = (IN_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int PADW = 2 * RW;

  logic              vld    [RW];
  logic [RW:0]       rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [PADW-1:0]   rad_q  [RW];
  logic [SIDE_W-1:0] side_q [RW];

  logic              vld_i  [RW];
  logic [RW:0]       rem_i  [RW];
  logic [RW-1:0]     root_i [RW];
  logic [PADW-1:0]   rad_i  [RW];
  logic [SIDE_W-1:0] side_i [RW];
  logic [RW:0]       rem_n  [RW];
  logic [RW-1:0]     root_n [RW];

  // stage inputs: the ports feed the first stage
  always_comb begin
    vld_i[0]  = in_valid;
    rem_i[0]  = '0;
    root_i[0] = '0;
    rad_i[0]  = PADW'(radicand);
    side_i[0] = side_in;
    for (int s = 1; s < RW; s++) begin
      vld_i[s]  = vld[s-1];
      rem_i[s]  = rem_q[s-1];
      root_i[s] = root_q[s-1];
      rad_i[s]  = rad_q[s-1];
      side_i[s] = side_q[s-1];
    end
  end

  // bring down two radicand bits, try root*4+1
  always_comb begin : sqrt_step
    logic [RW+2:0] rs;
    logic [RW+2:0] trial;
    for (int s = 0; s < RW; s++) begin
      rs    = {rem_i[s], rad_i[s][PADW-1-2*s -: 2]};
      trial = {1'b0, root_i[s], 2'b01};
      if (rs >= trial) begin
        rem_n[s]  = (RW+1)'(rs - trial);
        root_n[s] = {root_i[s][RW-2:0], 1'b1};
      end else begin
        rem_n[s]  = rs[RW:0];
        root_n[s] = {root_i[s][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < RW; s++) vld[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < RW; s++) vld[s] <= vld_i[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < RW; s++) begin
        rem_q[s]  <= rem_n[s];
        root_q[s] <= root_n[s];
        rad_q[s]  <= rad_i[s];
        side_q[s] <= side_i[s];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = root_q[RW-1];
  assign side_out  = side_q[RW-1];

endmodule

// ----- design/tivg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_div
// Pipelined rounded division of three lanes by one shared divisor: a
// rounding stage, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module tivg_div import tivg_pkg::*; #(
  parameter int MAG_W  = 49,
  parameter int SHIFT  = 8,
  parameter int DEN_W  = 33,
  parameter int QW     = 26,
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][MAG_W-1:0] mag,
  input  logic [DEN_W-1:0]          den,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [LANES-1:0][QW-1:0]  quo,
  output logic [SIDE_W-1:0]         side_out
);

  localparam int NUMW = MAG_W + SHIFT + 1;

  logic                        vp;
  logic [LANES-1:0][NUMW-1:0]  num_p;
  logic [DEN_W-1:0]            den_p;
  logic [SIDE_W-1:0]           side_p;

  logic                        vld   [QW];
  logic [LANES-1:0][DEN_W-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0]    low_q [QW];
  logic [LANES-1:0][QW-1:0]    q_q   [QW];
  logic [DEN_W-1:0]            den_q [QW];
  logic [SIDE_W-1:0]           side_q[QW];

  logic                        vld_i [QW];
  logic [LANES-1:0][DEN_W-1:0] rem_i [QW];
  logic [LANES-1:0][QW-1:0]    low_i [QW];
  logic [LANES-1:0][QW-1:0]    q_i   [QW];
  logic [DEN_W-1:0]            den_i [QW];
  logic [SIDE_W-1:0]           side_i[QW];
  logic [LANES-1:0][DEN_W-1:0] rem_n [QW];
  logic [LANES-1:0][QW-1:0]    q_n   [QW];

  // add half the divisor for round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        num_p[l] <= NUMW'({mag[l], {SHIFT{1'b0}}}) + NUMW'(den >> 1);
      end
      den_p  <= den;
      side_p <= side_in;
    end
  end

  // stage inputs; the quotient fits QW bits, so the top part seeds the remainder
  always_comb begin
    vld_i[0]  = vp;
    den_i[0]  = den_p;
    side_i[0] = side_p;
    for (int l = 0; l < LANES; l++) begin
      rem_i[0][l] = DEN_W'(num_p[l] >> QW);
      low_i[0][l] = num_p[l][QW-1:0];
      q_i[0][l]   = '0;
    end
    for (int s = 1; s < QW; s++) begin
      vld_i[s]  = vld[s-1];
      rem_i[s]  = rem_q[s-1];
      low_i[s]  = low_q[s-1];
      q_i[s]    = q_q[s-1];
      den_i[s]  = den_q[s-1];
      side_i[s] = side_q[s-1];
    end
  end

  // shift in one dividend bit, subtract the divisor when it fits
  always_comb begin : div_step
    logic [DEN_W:0] rs;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rs = {rem_i[s][l], low_i[s][l][QW-1-s]};
        if (rs >= {1'b0, den_i[s]}) begin
          rem_n[s][l] = DEN_W'(rs - {1'b0, den_i[s]});
          q_n[s][l]   = {q_i[s][l][QW-2:0], 1'b1};
        end else begin
          rem_n[s][l] = rs[DEN_W-1:0];
          q_n[s][l]   = {q_i[s][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) vld[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < QW; s++) vld[s] <= vld_i[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s]  <= rem_n[s];
        low_q[s]  <= low_i[s];
        q_q[s]    <= q_n[s];
        den_q[s]  <= den_i[s];
        side_q[s] <= side_i[s];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q_q[QW-1];
  assign side_out  = side_q[QW-1];

endmodule

// ----- design/tivg_fin.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_fin
// Result pipeline: offset to the core circle, squared distance, gradient
// rounding, on-axis select, flip and saturation (four stages).
// ----------------------------------------------------------------------------
module tivg_fin import tivg_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  localparam int VW   = vec_w(COORD_WIDTH),
  localparam int QW   = quo_w(FRAC_BITS),
  localparam int PSQW = psq_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][VW-1:0]      vec,
  input  logic [LANES-1:0]              perp_neg,
  input  logic [LANES-1:0][QW-1:0]      quo,
  input  logic [PSQW-1:0]               para_sq,
  input  logic                          on_axis_in,
  input  logic [RAD_W-1:0]              ring_radius,
  input  logic [RAD_W-1:0]              tube_radius,
  input  logic                          flipped,
  output logic                          out_valid,
  output logic [VALUE_W-1:0]            implicit_value,
  output logic [LANES-1:0][GRAD_W-1:0]  grad,
  output logic                          on_axis
);

  localparam int DFW = dif_w(COORD_WIDTH, FRAC_BITS);
  localparam int PRW = PSQW + 1 - 2 * FRAC_BITS;
  localparam int DSW = 2 * DFW + 2;
  localparam int GIW = max2(DFW - FRAC_BITS + 2, VW + 1) + 1;
  localparam int VIW = max2(max2(DSW + 1, PSQW + 1), 2 * RAD_W + 1) + 2;
  localparam int RSQ = 2 * RAD_W;

  localparam logic [PSQW:0]        PSQ_HALF = (PSQW+1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic [DSW:0]         DSQ_HALF = (DSW+1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [DFW:0]  GD_HALF  = (DFW+1)'(1) << (FRAC_BITS - 2);
  localparam logic signed [VIW-1:0] VMAX = VIW'({(VALUE_W-1){1'b1}});
  localparam logic signed [VIW-1:0] VMIN = -VMAX - VIW'(1);
  localparam logic signed [GIW-1:0] GMAX = GIW'({(GRAD_W-1){1'b1}});
  localparam logic signed [GIW-1:0] GMIN = -GMAX - GIW'(1);

  logic                        v1, v2, v3, v4;
  logic signed [QW:0]          rn_n  [LANES];
  logic signed [DFW-1:0]       d_n   [LANES];
  logic [LANES-1:0][DFW-1:0]   d1;
  logic [LANES-1:0][VW-1:0]    vec1;
  logic [PSQW:0]               psq_rnd;
  logic [PRW-1:0]              psqr1;
  logic [RSQ-1:0]              rr1, r21, r22;
  logic                        on1, on2, on3;
  logic [LANES-1:0][2*DFW-1:0] dsq2;
  logic signed [DFW:0]         gd_rnd [LANES];
  logic signed [GIW-1:0]       gd2 [LANES];
  logic signed [GIW-1:0]       gv2 [LANES];
  logic signed [VIW-1:0]       vax2;
  logic [DSW:0]                dsum;
  logic signed [VIW-1:0]       voff;
  logic signed [VIW-1:0]       vsel;
  logic signed [GIW-1:0]       gsel [LANES];
  logic signed [VIW-1:0]       v3q;
  logic signed [GIW-1:0]       g3q [LANES];
  logic [VALUE_W-1:0]          val4;
  logic [LANES-1:0][GRAD_W-1:0] g4;
  logic                        on4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // signed offset from the nearest core-circle point, rounded squared lengths
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rn_n[i]   = perp_neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      d_n[i]    = (DFW'($signed(vec[i])) <<< FRAC_BITS) - DFW'(rn_n[i]);
      gd_rnd[i] = (DFW+1)'($signed(d1[i])) + GD_HALF;
    end
    psq_rnd = (PSQW+1)'(para_sq) + PSQ_HALF;
    dsum    = (DSW+1)'(dsq2[0]) + (DSW+1)'(dsq2[1]) + (DSW+1)'(dsq2[2]) + DSQ_HALF;
    voff    = VIW'(dsum >> (2 * FRAC_BITS)) - VIW'(r22);
    vsel    = on2 ? vax2 : voff;
    for (int i = 0; i < LANES; i++) begin
      gsel[i] = on2 ? gv2[i] : gd2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int i = 0; i < LANES; i++) d1[i] <= d_n[i];
      vec1  <= vec;
      psqr1 <= PRW'(psq_rnd >> (2 * FRAC_BITS));
      rr1   <= RSQ'(ring_radius) * RSQ'(ring_radius);
      r21   <= RSQ'(tube_radius) * RSQ'(tube_radius);
      on1   <= on_axis_in;
      // stage 2
      for (int i = 0; i < LANES; i++) begin
        dsq2[i] <= (2*DFW)'($signed(d1[i])) * (2*DFW)'($signed(d1[i]));
        gd2[i]  <= GIW'(gd_rnd[i] >>> (FRAC_BITS - 1));
        gv2[i]  <= GIW'($signed(vec1[i])) <<< 1;
      end
      vax2 <= VIW'(psqr1) + VIW'(rr1) - VIW'(r21);
      r22  <= r21;
      on2  <= on1;
      // stage 3: select and flip
      v3q <= flipped ? -vsel : vsel;
      for (int i = 0; i < LANES; i++) begin
        g3q[i] <= flipped ? -gsel[i] : gsel[i];
      end
      on3 <= on2;
      // stage 4: saturate into the output register
      val4 <= (v3q > VMAX) ? VALUE_W'(VMAX) :
              (v3q < VMIN) ? VALUE_W'(VMIN) : VALUE_W'(v3q);
      for (int i = 0; i < LANES; i++) begin
        g4[i] <= (g3q[i] > GMAX) ? GRAD_W'(GMAX) :
                 (g3q[i] < GMIN) ? GRAD_W'(GMIN) : GRAD_W'(g3q[i]);
      end
      on4 <= on3;
    end
  end

  assign out_valid      = v4;
  assign implicit_value = val4;
  assign grad           = g4;
  assign on_axis        = on4;

endmodule

// ----- design/torus_implicit_value_gradient_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_implicit_value_gradient_core
// Torus implicit value and gradient for one query point per beat.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: point_x, point_y, point_z
//  m_axis    out  m_axis_tvalid/tready      tdata: value, grad x/y/z; tuser: on_axis
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  One point enters per cycle while the pipeline is not held. Items pass the
//  projection, square root (root width PW = 33), rounding, division (quotient
//  width QW = 26) and result pipelines, in that order, at default parameters.
//  Reset is synchronous; it clears valid bits and loads register defaults.
//  The whole pipeline holds while a result waits on m_axis, and s_axis_tready
//  follows that hold; bubbles fill as long as the output register is free.
// ----------------------------------------------------------------------------
module torus_implicit_value_gradient_core import tivg_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  localparam int IN_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int CFG_W      = max2(3 * COORD_WIDTH, 3 * AXIS_W)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // point_x, point_y, point_z, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // implicit_value, grad_x, grad_y, grad_z, pad
  output logic [0:0]             m_axis_tuser,   // on_axis
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int VW   = vec_w(COORD_WIDTH);
  localparam int PW   = perp_w(COORD_WIDTH, FRAC_BITS);
  localparam int MW   = mag_w(COORD_WIDTH, FRAC_BITS);
  localparam int SQW  = 2 * PW;
  localparam int PSQW = psq_w(COORD_WIDTH, FRAC_BITS);
  localparam int QW   = quo_w(FRAC_BITS);
  localparam int RTW  = (SQW + 1) / 2;

  typedef struct packed {
    logic                     on_axis;
    logic [PSQW-1:0]          para_sq;
    logic [LANES-1:0]         perp_neg;
    logic [LANES-1:0][VW-1:0] vec;
  } item_side_t;

  typedef struct packed {
    logic [LANES-1:0][MW-1:0] mag;
    item_side_t               item;
  } root_side_t;

  logic [3*COORD_WIDTH-1:0] center_xyz;
  logic [3*AXIS_W-1:0]      axis_xyz;
  logic [RAD_W-1:0]         ring_radius;
  logic [RAD_W-1:0]         tube_radius;
  logic                     flipped;

  logic                     en;
  logic                     pj_valid;
  logic [LANES-1:0][VW-1:0] pj_vec;
  logic [LANES-1:0]         pj_neg;
  logic [LANES-1:0][MW-1:0] pj_mag;
  logic [SQW-1:0]           pj_sq;
  logic [PSQW-1:0]          pj_psq;
  root_side_t               rt_side_in, rt_side_out;
  logic                     rt_valid;
  logic [RTW-1:0]           rt_norm;
  logic                     dv_valid;
  logic [LANES-1:0][QW-1:0] dv_quo;
  item_side_t               dv_side;
  logic [VALUE_W-1:0]       value;
  logic [LANES-1:0][GRAD_W-1:0] grad;
  logic                     on_axis;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_xyz  <= '0;
      axis_xyz    <= (3*AXIS_W)'(1) << (2 * AXIS_W + AXIS_FRAC);
      ring_radius <= RAD_W'(2 << FRAC_BITS);
      tube_radius <= RAD_W'(1 << FRAC_BITS);
      flipped     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER: center_xyz  <= cfg_data[3*COORD_WIDTH-1:0];
        REG_AXIS:   axis_xyz    <= cfg_data[3*AXIS_W-1:0];
        REG_MAJOR:  ring_radius <= cfg_data[RAD_W-1:0];
        REG_MINOR:  tube_radius <= cfg_data[RAD_W-1:0];
        REG_FLIP:   flipped     <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // advance everything unless the output register holds an untaken beat
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tivg_proj #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_proj (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_axis_tvalid),
    .point       (s_axis_tdata[3*COORD_WIDTH-1:0]),
    .center      (center_xyz),
    .axis        (axis_xyz),
    .ring_radius (ring_radius),
    .out_valid   (pj_valid),
    .vec         (pj_vec),
    .perp_neg    (pj_neg),
    .mag         (pj_mag),
    .perp_sq     (pj_sq),
    .para_sq     (pj_psq)
  );

  always_comb begin
    rt_side_in.mag           = pj_mag;
    rt_side_in.item.on_axis  = (pj_sq == '0);
    rt_side_in.item.para_sq  = pj_psq;
    rt_side_in.item.perp_neg = pj_neg;
    rt_side_in.item.vec      = pj_vec;
  end

  tivg_sqrt #(
    .IN_W   (SQW),
    .SIDE_W ($bits(root_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pj_valid),
    .radicand  (pj_sq),
    .side_in   (rt_side_in),
    .out_valid (rt_valid),
    .root      (rt_norm),
    .side_out  (rt_side_out)
  );

  tivg_div #(
    .MAG_W  (MW),
    .SHIFT  (FRAC_BITS),
    .DEN_W  (RTW),
    .QW     (QW),
    .SIDE_W ($bits(item_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_valid),
    .mag       (rt_side_out.mag),
    .den       (rt_norm),
    .side_in   (rt_side_out.item),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (dv_side)
  );

  tivg_fin #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_fin (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (dv_valid),
    .vec            (dv_side.vec),
    .perp_neg       (dv_side.perp_neg),
    .quo            (dv_quo),
    .para_sq        (dv_side.para_sq),
    .on_axis_in     (dv_side.on_axis),
    .ring_radius    (ring_radius),
    .tube_radius    (tube_radius),
    .flipped        (flipped),
    .out_valid      (m_axis_tvalid),
    .implicit_value (value),
    .grad           (grad),
    .on_axis        (on_axis)
  );

  // pack the result beat
  assign m_axis_tdata = OUT_TDATA_W'({grad[2], grad[1], grad[0], value});
  assign m_axis_tuser = on_axis;

endmodule

// ----- design/tivg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivg_checker
// Port-level checks on stall behavior and reset of the torus core.
// ----------------------------------------------------------------------------
module tivg_checker import tivg_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  // a stalled result beat holds its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // a stalled result beat holds its on-axis flag
  a_hold_user: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
    else $error("result flag changed while stalled");

  // input side opens exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind torus_implicit_value_gradient_core tivg_checker u_tivg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
